### design/cpqm_pkg.sv
// ----------------------------------------------------------------------------
// cpqm_pkg: shared types and constants
// Gain sets, lane control and status groups, register indexes and the
// gyro scale used by the cascaded PID quad mixer.
// ----------------------------------------------------------------------------
package cpqm_pkg;

  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CFG_IX_W = 3;

  // 1.1459156 in unsigned Q2.16
  localparam logic [17:0] GYRO_SCALE = 18'd75099;

  localparam logic [CFG_IX_W-1:0] REG_OUTER_KP = 3'd0;
  localparam logic [CFG_IX_W-1:0] REG_OUTER_KI = 3'd1;
  localparam logic [CFG_IX_W-1:0] REG_OUTER_KD = 3'd2;
  localparam logic [CFG_IX_W-1:0] REG_INNER_KP = 3'd3;
  localparam logic [CFG_IX_W-1:0] REG_INNER_KI = 3'd4;
  localparam logic [CFG_IX_W-1:0] REG_INNER_KD = 3'd5;

  localparam logic signed [GAIN_W-1:0] INNER_KP_RESET = 24'sd19661;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic ack;
  } lane_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_sts_t;

endpackage

### design/cpqm_lane.sv
// ----------------------------------------------------------------------------
// cpqm_lane: one axis of the cascaded controller
// Runs the angle PID and then the rate PID of one axis on a single
// multiplier, one product per cycle, and holds the rate loop output.
// ----------------------------------------------------------------------------
module cpqm_lane
  import cpqm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctl_t               ctl_i,
  input  logic signed [15:0]      err_i,
  input  logic signed [15:0]      gyro_i,
  input  gains_t                  outer_gains_i,
  input  gains_t                  inner_gains_i,
  output lane_sts_t               sts_o,
  output logic signed [VAL_W-1:0] y_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [2:0] CNT_UPD = 3'd4;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [44:0] v);
    logic signed [44:0] hi;
    logic signed [44:0] lo;
    hi = 45'sd2147483647;
    lo = -45'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[VAL_W-1:0];
    end
  endfunction

  logic [1:0]               state_q;
  logic                     stage_q;
  logic [2:0]               cnt_q;
  logic signed [VAL_W-1:0]  x_q;
  logic signed [33:0]       gprod_q;
  logic signed [57:0]       prod_q;
  logic signed [59:0]       acc_q;
  logic signed [VAL_W-1:0]  hin1_q [2];
  logic signed [VAL_W-1:0]  hin2_q [2];
  logic signed [VAL_W-1:0]  hout_q [2];
  logic signed [VAL_W-1:0]  y_q;

  gains_t                   g;
  logic signed [25:0]       coef;
  logic signed [VAL_W-1:0]  opnd;
  logic signed [57:0]       mul;
  logic signed [VAL_W-1:0]  y_new;
  logic signed [VAL_W-1:0]  gyr;
  logic signed [VAL_W-1:0]  x_inner;

  always_comb begin
    g = stage_q ? inner_gains_i : outer_gains_i;
    case (cnt_q[1:0])
      2'd0: begin
        coef = 26'(g.kp) + 26'(g.ki) + 26'(g.kd);
        opnd = x_q;
      end
      2'd1: begin
        coef = -26'(g.kp) - (26'(g.kd) <<< 1);
        opnd = hin1_q[stage_q];
      end
      2'd2: begin
        coef = 26'(g.kd);
        opnd = hin2_q[stage_q];
      end
      default: begin
        coef = '0;
        opnd = '0;
      end
    endcase
    mul     = 58'(coef) * 58'(opnd);
    y_new   = sat32(45'(hout_q[stage_q]) + 45'(acc_q >>> 16));
    gyr     = 32'(gprod_q >>> 12);
    x_inner = sat32(45'(y_new) - 45'(gyr));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= 1'b0;
      cnt_q   <= '0;
      for (int i = 0; i < 2; i++) begin
        hin1_q[i] <= '0;
        hin2_q[i] <= '0;
        hout_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (ctl_i.start) begin
            if (ctl_i.clear) begin
              for (int i = 0; i < 2; i++) begin
                hin1_q[i] <= '0;
                hin2_q[i] <= '0;
                hout_q[i] <= '0;
              end
            end
            stage_q <= 1'b0;
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cnt_q == CNT_UPD) begin
            hin2_q[stage_q] <= hin1_q[stage_q];
            hin1_q[stage_q] <= x_q;
            hout_q[stage_q] <= y_new;
            cnt_q           <= '0;
            if (!stage_q) begin
              stage_q <= 1'b1;
            end else begin
              state_q <= ST_DONE;
            end
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_DONE: begin
          if (ctl_i.ack) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: operand, product and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && ctl_i.start) begin
      x_q     <= 32'(err_i) <<< 8;
      gprod_q <= 34'(gyro_i) * 34'($signed({1'b0, GYRO_SCALE}));
    end else if (state_q == ST_RUN) begin
      prod_q <= mul;
      if (cnt_q == 3'd1) begin
        acc_q <= 60'(prod_q);
      end else if (cnt_q != 3'd0 && cnt_q != CNT_UPD) begin
        acc_q <= acc_q + 60'(prod_q);
      end
      if (cnt_q == CNT_UPD) begin
        if (!stage_q) begin
          x_q <= x_inner;
        end else begin
          y_q <= y_new;
        end
      end
    end
  end

  assign sts_o.idle = (state_q == ST_IDLE);
  assign sts_o.done = (state_q == ST_DONE);
  assign y_o        = y_q;

endmodule

### design/cpqm_mix.sv
// ----------------------------------------------------------------------------
// cpqm_mix: X-quad motor mixer and output register
// Combines the three rate loop outputs with the thrust into four motor
// values and holds them for the downstream side.
// ----------------------------------------------------------------------------
module cpqm_mix
  import cpqm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ack_o,
  input  logic signed [VAL_W-1:0] roll_i,
  input  logic signed [VAL_W-1:0] pitch_i,
  input  logic signed [VAL_W-1:0] yaw_i,
  input  logic [15:0]             thrust_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [63:0]             data_o
);

  function automatic logic [15:0] motor(input logic signed [35:0] s);
    logic signed [35:0] t;
    logic signed [19:0] q;
    t = (s < 0) ? s + 36'sd65535 : s;
    q = 20'(t >>> 16);
    if (q > 20'sd32767) begin
      motor = 16'h7fff;
    end else if (q < -20'sd32768) begin
      motor = 16'h8000;
    end else begin
      motor = q[15:0];
    end
  endfunction

  logic               valid_q;
  logic [63:0]        data_q;
  logic signed [35:0] t, r, p, y;

  always_comb begin
    t = $signed({4'd0, thrust_i, 16'd0});
    r = 36'(roll_i);
    p = 36'(pitch_i);
    y = 36'(yaw_i);
  end

  assign ack_o = valid_i && (!valid_q || ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ack_o) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack_o) begin
      data_q <= {motor(t + r - p - y), motor(t + r + p + y),
                 motor(t - r + p - y), motor(t - r - p + y)};
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/cascaded_pid_quad_mixer.sv
// ----------------------------------------------------------------------------
// cascaded_pid_quad_mixer: cascaded incremental PID with X-quad mixing
// Three axis lanes run angle and rate PIDs side by side; the mixer merges
// their outputs with thrust into four saturated motor commands.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata 112b, tuser 1b
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata 64b
//  cfg       in         cfg_we_i                     cfg_index_i, cfg_wdata_i
//
// For each item, each lane runs two PIDs through its single multiplier, one
// after the other, each taking three products, a final accumulate step and
// an update step; the mixer then moves the lane results into the output
// register. The input accepts a new item only once all lanes are idle
// again, so an item must leave the lanes before the next one is taken.
// Reset clears all PID histories and loads the gain reset values. A stalled
// output holds its item; lanes then hold their results until the output
// register frees.
module cascaded_pid_quad_mixer
  import cpqm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // roll_error, pitch_error, yaw_error, gyro_x, gyro_y, gyro_z, thrust
  input  logic [111:0]          s_axis_tdata,
  // clear_history
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // motor_one, motor_two, motor_three, motor_four
  output logic [63:0]           m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IX_W-1:0]   cfg_index_i,
  input  logic [GAIN_W-1:0]     cfg_wdata_i
);

  gains_t    outer_q;
  gains_t    inner_q;
  logic [15:0] thrust_q;

  lane_ctl_t ctl;
  lane_sts_t sts [3];
  logic signed [VAL_W-1:0] lane_y [3];
  logic signed [15:0] err  [3];
  logic signed [15:0] gyro [3];
  logic      mix_ack;
  logic      accept;

  // Gain registers; unknown indexes drop the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= '0;
      inner_q <= '{kp: INNER_KP_RESET, ki: '0, kd: '0};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_OUTER_KP: outer_q.kp <= cfg_wdata_i;
        REG_OUTER_KI: outer_q.ki <= cfg_wdata_i;
        REG_OUTER_KD: outer_q.kd <= cfg_wdata_i;
        REG_INNER_KP: inner_q.kp <= cfg_wdata_i;
        REG_INNER_KI: inner_q.ki <= cfg_wdata_i;
        REG_INNER_KD: inner_q.kd <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Accept only when every lane is idle.
  assign s_axis_tready = sts[0].idle && sts[1].idle && sts[2].idle;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      thrust_q <= s_axis_tdata[111:96];
    end
  end

  assign ctl.start = accept;
  assign ctl.clear = s_axis_tuser;
  assign ctl.ack   = mix_ack;

  // Roll pairs with gyro y, pitch with gyro x, yaw with gyro z.
  assign err[0]  = s_axis_tdata[15:0];
  assign err[1]  = s_axis_tdata[31:16];
  assign err[2]  = s_axis_tdata[47:32];
  assign gyro[0] = s_axis_tdata[79:64];
  assign gyro[1] = s_axis_tdata[63:48];
  assign gyro[2] = s_axis_tdata[95:80];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    cpqm_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .err_i         (err[i]),
      .gyro_i        (gyro[i]),
      .outer_gains_i (outer_q),
      .inner_gains_i (inner_q),
      .sts_o         (sts[i]),
      .y_o           (lane_y[i])
    );
  end

  // Lanes run in lockstep, so lane 0 speaks for all.
  cpqm_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sts[0].done),
    .ack_o    (mix_ack),
    .roll_i   (lane_y[0]),
    .pitch_i  (lane_y[1]),
    .yaw_i    (lane_y[2]),
    .thrust_i (thrust_q),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .data_o   (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts[0].done == sts[1].done) && (sts[0].done == sts[2].done) &&
    (sts[0].idle == sts[2].idle))
    else $error("lanes out of lockstep");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input ready right after accept");

  a_out_from_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(sts[0].done))
    else $error("output valid without finished lanes");
`endif

endmodule
